### hw/rtl/erm_pkg.sv
package erm_pkg;

    localparam int ANGLE_W   = 16;
    localparam int ELEM_W    = 16;
    localparam int DEF_STAGES = 16;
    localparam int FRAC      = 30;
    localparam int CW        = 34;
    localparam int EW        = 32;
    localparam int TW        = 34;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] first_angle;
        logic signed [ANGLE_W-1:0] second_angle;
        logic signed [ANGLE_W-1:0] third_angle;
        logic [1:0]                first_axis;
        logic [1:0]                second_axis;
        logic [1:0]                third_axis;
    } t_in;

    typedef struct packed {
        logic signed [ELEM_W-1:0] r00;
        logic signed [ELEM_W-1:0] r01;
        logic signed [ELEM_W-1:0] r02;
        logic signed [ELEM_W-1:0] r10;
        logic signed [ELEM_W-1:0] r11;
        logic signed [ELEM_W-1:0] r12;
        logic signed [ELEM_W-1:0] r20;
        logic signed [ELEM_W-1:0] r21;
        logic signed [ELEM_W-1:0] r22;
    } t_out;

    typedef logic signed [EW-1:0] t_el;
    typedef t_el t_mat [3][3];

    function automatic logic signed [CW-1:0] atan_q30(input int i);
        case (i)
            0: atan_q30 = 34'sd843314856;
            1: atan_q30 = 34'sd497837829;
            2: atan_q30 = 34'sd263043836;
            3: atan_q30 = 34'sd133525158;
            4: atan_q30 = 34'sd67021686;
            5: atan_q30 = 34'sd33543515;
            6: atan_q30 = 34'sd16775850;
            7: atan_q30 = 34'sd8388437;
            8: atan_q30 = 34'sd4194282;
            9: atan_q30 = 34'sd2097149;
            10: atan_q30 = 34'sd1048575;
            11: atan_q30 = 34'sd524287;
            12: atan_q30 = 34'sd262143;
            13: atan_q30 = 34'sd131071;
            14: atan_q30 = 34'sd65535;
            15: atan_q30 = 34'sd32767;
            16: atan_q30 = 34'sd16383;
            17: atan_q30 = 34'sd8191;
            18: atan_q30 = 34'sd4095;
            19: atan_q30 = 34'sd2047;
            20: atan_q30 = 34'sd1023;
            21: atan_q30 = 34'sd511;
            22: atan_q30 = 34'sd255;
            23: atan_q30 = 34'sd127;
            24: atan_q30 = 34'sd63;
            25: atan_q30 = 34'sd31;
            26: atan_q30 = 34'sd15;
            27: atan_q30 = 34'sd8;
            28: atan_q30 = 34'sd4;
            29: atan_q30 = 34'sd2;
            30: atan_q30 = 34'sd1;
            default: atan_q30 = 34'sd0;
        endcase
    endfunction

    function automatic t_mat elementary(input t_el c, input t_el s, input logic [1:0] axis);
        t_mat m;
        t_el one;
        one = t_el'(64'sd1 <<< FRAC);
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                m[r][k] = (r == k) ? one : '0;
            end
        end
        unique case (axis)
            AXIS_X: begin
                m[1][1] = c; m[1][2] = -s; m[2][1] = s; m[2][2] = c;
            end
            AXIS_Y: begin
                m[0][0] = c; m[0][2] = s; m[2][0] = -s; m[2][2] = c;
            end
            AXIS_Z: begin
                m[0][0] = c; m[0][1] = -s; m[1][0] = s; m[1][1] = c;
            end
            default: ;
        endcase
        return m;
    endfunction

endpackage

### hw/rtl/erm_cordic.sv
module erm_cordic
    import erm_pkg::*;
#(
    parameter int SINCOS_STAGES = DEF_STAGES
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic [1:0]                i_axis,
    output t_el                       o_cos,
    output t_el                       o_sin,
    output logic [1:0]                o_axis
);

    localparam int ZSH = FRAC + 3 - ANGLE_W;

    logic signed [CW-1:0] r_x [SINCOS_STAGES+1];
    logic signed [CW-1:0] r_y [SINCOS_STAGES+1];
    logic signed [CW-1:0] r_z [SINCOS_STAGES+1];
    logic                 r_f [SINCOS_STAGES+1];
    logic [1:0]           r_a [SINCOS_STAGES+1];

    logic signed [CW-1:0] z_in;
    logic signed [CW-1:0] n_z;
    logic                 n_f;

    // range reduction into +-pi/2
    always_comb begin
        z_in = CW'(i_angle) <<< ZSH;
        n_z  = z_in;
        n_f  = 1'b0;
        if (z_in > HALF_PI_Q30) begin
            n_z = z_in - PI_Q30;
            n_f = 1'b1;
        end else if (z_in < -HALF_PI_Q30) begin
            n_z = z_in + PI_Q30;
            n_f = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= n_z;
            r_f[0] <= n_f;
            r_a[0] <= i_axis;
        end
    end

    for (genvar g = 0; g < SINCOS_STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q30(g);
                end
                r_f[g+1] <= r_f[g];
                r_a[g+1] <= r_a[g];
            end
        end
    end

    assign o_cos  = r_f[SINCOS_STAGES] ? EW'(-r_x[SINCOS_STAGES]) : EW'(r_x[SINCOS_STAGES]);
    assign o_sin  = r_f[SINCOS_STAGES] ? EW'(-r_y[SINCOS_STAGES]) : EW'(r_y[SINCOS_STAGES]);
    assign o_axis = r_a[SINCOS_STAGES];

endmodule

### hw/rtl/erm_matmul.sv
module erm_matmul
    import erm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  t_el        i_cos [3],
    input  t_el        i_sin [3],
    input  logic [1:0] i_axis [3],
    output t_out       o_data
);

    localparam int PW  = 2 * EW;
    localparam int QW  = TW + EW;
    localparam int SH  = FRAC + 2 - ELEM_W;
    localparam int LIM = 1 << (ELEM_W - 2);

    logic signed [PW-1:0] r_p1 [3][3][3];
    logic signed [TW-1:0] r_t  [3][3];
    logic signed [QW-1:0] r_p2 [3][3][3];
    t_el                  r_c3 [2];
    t_el                  r_s3 [2];
    logic [1:0]           r_a3 [2];
    t_out                 r_out;

    t_mat m1, m2, m3;
    logic signed [ELEM_W-1:0] res [9];

    always_comb begin
        m1 = elementary(i_cos[0], i_sin[0], i_axis[0]);
        m2 = elementary(i_cos[1], i_sin[1], i_axis[1]);
        m3 = elementary(r_c3[1], r_s3[1], r_a3[1]);
    end

    // stage a: first products, third lane delayed
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    for (int j = 0; j < 3; j++)
                        r_p1[r][k][j] <= PW'(m1[r][j]) * PW'(m2[j][k]);
            r_c3[0] <= i_cos[2];
            r_s3[0] <= i_sin[2];
            r_a3[0] <= i_axis[2];
            r_c3[1] <= r_c3[0];
            r_s3[1] <= r_s3[0];
            r_a3[1] <= r_a3[0];
        end
    end

    // stage b: sum and round back to q4.30
    always_ff @(posedge i_clk) begin
        logic signed [PW+1:0] acc;
        if (i_en) begin
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++) begin
                    acc = (PW+2)'(r_p1[r][k][0]) + (PW+2)'(r_p1[r][k][1])
                        + (PW+2)'(r_p1[r][k][2]) + ((PW+2)'(1) <<< (FRAC - 1));
                    r_t[r][k] <= TW'(acc >>> FRAC);
                end
        end
    end

    // stage c: second products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    for (int j = 0; j < 3; j++)
                        r_p2[r][k][j] <= QW'(r_t[r][j]) * QW'(m3[j][k]);
        end
    end

    // stage d: sum, round twice, saturate
    always_comb begin
        logic signed [QW+1:0] acc;
        logic signed [QW+1:0] q;
        logic signed [QW+1:0] v;
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++) begin
                acc = (QW+2)'(r_p2[r][k][0]) + (QW+2)'(r_p2[r][k][1])
                    + (QW+2)'(r_p2[r][k][2]) + ((QW+2)'(1) <<< (FRAC - 1));
                q = acc >>> FRAC;
                if (SH > 0) v = (q + ((QW+2)'(1) <<< (SH - 1))) >>> SH;
                else        v = q;
                if (v > (QW+2)'(LIM))        v = (QW+2)'(LIM);
                if (v < -((QW+2)'(LIM)))     v = -((QW+2)'(LIM));
                res[r*3+k] = ELEM_W'(v);
            end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.r00 <= res[0];
            r_out.r01 <= res[1];
            r_out.r02 <= res[2];
            r_out.r10 <= res[3];
            r_out.r11 <= res[4];
            r_out.r12 <= res[5];
            r_out.r20 <= res[6];
            r_out.r21 <= res[7];
            r_out.r22 <= res[8];
        end
    end

    assign o_data = r_out;

endmodule

### hw/rtl/euler_angles_to_rotation_matrix_core.sv
// euler angle to 3x3 rotation matrix, fixed point, fully pipelined
//
// input channel: i_valid / o_ready, word i_data carries three q3.13 angles
// and three axis codes (x, y, z, or identity for code 3)
// output channel: o_valid / i_ready, word o_data carries the nine q1.14
// elements of first * second * third, row by row, saturated to +-1.0
//
// the pipeline has one range reduction stage, one cordic stage per
// iteration in each of three sine/cosine lanes, then four stages of the
// merging matrix product (two multiply, two sum/round)
// throughput is one word per cycle while the receiver does not stall, set by the pipelined cordic lanes
//
// the pipeline advances as a whole whenever its last stage is empty or is
// being taken, so a new word is accepted in the same cycle a result leaves
// when the receiver stalls, the whole pipeline holds and o_ready drops
// reset clears the stage valid bits only; no state survives a word
module euler_angles_to_rotation_matrix_core
    import erm_pkg::*;
#(
    parameter int SINCOS_STAGES = DEF_STAGES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int DEPTH = SINCOS_STAGES + 5;

    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    logic             en;

    t_el        cs_cos  [3];
    t_el        cs_sin  [3];
    logic [1:0] cs_axis [3];

    // global advance enable
    assign en      = !r_vld[DEPTH-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[DEPTH-1];

    always_comb begin
        n_vld = r_vld;
        if (en) n_vld = {r_vld[DEPTH-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // three sine/cosine lanes
    erm_cordic #(.SINCOS_STAGES(SINCOS_STAGES)) u_lane0 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_angle(i_data.first_angle),
        .i_axis (i_data.first_axis),
        .o_cos  (cs_cos[0]),
        .o_sin  (cs_sin[0]),
        .o_axis (cs_axis[0])
    );

    erm_cordic #(.SINCOS_STAGES(SINCOS_STAGES)) u_lane1 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_angle(i_data.second_angle),
        .i_axis (i_data.second_axis),
        .o_cos  (cs_cos[1]),
        .o_sin  (cs_sin[1]),
        .o_axis (cs_axis[1])
    );

    erm_cordic #(.SINCOS_STAGES(SINCOS_STAGES)) u_lane2 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_angle(i_data.third_angle),
        .i_axis (i_data.third_axis),
        .o_cos  (cs_cos[2]),
        .o_sin  (cs_sin[2]),
        .o_axis (cs_axis[2])
    );

    // merge: elementary matrices and their product
    erm_matmul u_merge (
        .i_clk (i_clk),
        .i_en  (en),
        .i_cos (cs_cos),
        .i_sin (cs_sin),
        .i_axis(cs_axis),
        .o_data(o_data)
    );

endmodule

### tb/sv/euler_angles_to_rotation_matrix_core_test.sv
`timescale 1ns / 1ps

module euler_angles_to_rotation_matrix_core_test
    import erm_pkg::*;
;

    localparam int MAX_CYCLES = 200000;
    localparam int LATENCY = 16 + 5;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    // matrices predicted for words accepted but not yet returned
    t_out pending_matrices[$];
    int mismatch_count;
    int cycle_count;

    euler_angles_to_rotation_matrix_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // arithmetic shift right, floor rounding
    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    // cordic cosine and sine in q2.30, with reduction into +-pi/2
    function automatic void angle_sincos(input logic signed [15:0] ang,
                                         output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit flip;
        z = longint'(ang) * (longint'(1) << 17);
        flip = 1'b0;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = shift_floor(y, i);
            dy = shift_floor(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(atan_q30(i));
            end else begin
                x += dx;
                y -= dy;
                z += longint'(atan_q30(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    typedef longint rot_t[3][3];

    function automatic rot_t axis_rotation(logic signed [15:0] ang, logic [1:0] axis);
        rot_t m;
        longint c;
        longint s;
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
                m[r][k] = (r == k) ? (longint'(1) << 30) : 0;
        angle_sincos(ang, c, s);
        case (axis)
            AXIS_X: begin
                m[1][1] = c; m[1][2] = -s; m[2][1] = s; m[2][2] = c;
            end
            AXIS_Y: begin
                m[0][0] = c; m[0][2] = s; m[2][0] = -s; m[2][2] = c;
            end
            AXIS_Z: begin
                m[0][0] = c; m[0][1] = -s; m[1][0] = s; m[1][1] = c;
            end
            default: ;
        endcase
        return m;
    endfunction

    function automatic rot_t rot_product(rot_t a, rot_t b);
        rot_t p;
        longint acc;
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) acc += a[r][j] * b[j][k];
                p[r][k] = shift_floor(acc + (longint'(1) << 29), 30);
            end
        return p;
    endfunction

    function automatic t_out rotation_matrix(t_in w);
        rot_t p;
        longint v;
        logic signed [15:0] el[9];
        t_out res;
        p = rot_product(rot_product(axis_rotation(w.first_angle, w.first_axis),
                                    axis_rotation(w.second_angle, w.second_axis)),
                        axis_rotation(w.third_angle, w.third_axis));
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++) begin
                // round half up to q1.14, then clamp to +-1.0
                v = shift_floor(p[r][k] + (longint'(1) << 15), 16);
                if (v > 16384) v = 16384;
                if (v < -16384) v = -16384;
                el[r*3+k] = v[15:0];
            end
        res = '{el[0], el[1], el[2], el[3], el[4], el[5], el[6], el[7], el[8]};
        return res;
    endfunction

    // send one word, with a random hold-off before it
    task automatic send_word(t_in w);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_matrices.push_back(rotation_matrix(w));
    endtask

    function automatic t_in random_word();
        t_in w;
        w.first_angle = 16'($urandom);
        w.second_angle = 16'($urandom);
        w.third_angle = 16'($urandom);
        w.first_axis = 2'($urandom_range(0, 3));
        w.second_axis = 2'($urandom_range(0, 3));
        w.third_axis = 2'($urandom_range(0, 3));
        return w;
    endfunction

    // receiver side: random wait per word, compare every element of each word
    initial begin
        t_out want;
        int wait_left;
        i_ready = 1'b0;
        wait_left = $urandom_range(0, 3);
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_matrices.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word %h", o_data);
                end else begin
                    want = pending_matrices.pop_front();
                    if (want !== o_data) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %h actual %h", want, o_data);
                    end
                end
                wait_left = $urandom_range(0, 3);
            end
            i_ready <= (wait_left == 0);
            if (wait_left > 0) wait_left--;
        end
    end

    // cycle limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > MAX_CYCLES) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic test_identity_and_axes();
        t_in w;
        w = '0;
        w.first_axis = AXIS_NONE; w.second_axis = AXIS_NONE; w.third_axis = AXIS_NONE;
        w.first_angle = 16'sh7fff;
        send_word(w);
        for (int a = 0; a < 3; a++) begin
            w = '0;
            w.first_axis = 2'(a); w.second_axis = AXIS_NONE; w.third_axis = AXIS_NONE;
            w.first_angle = 16'sd6434;   // about pi/4
            send_word(w);
            w.first_axis = AXIS_NONE; w.second_axis = 2'(a);
            send_word(w);
            w.second_axis = AXIS_NONE; w.third_axis = 2'(a);
            send_word(w);
        end
    endtask

    // extremes of the angle range and the reduction boundary near +-pi/2
    task automatic test_angle_extremes();
        t_in w;
        logic signed [15:0] corner[6] = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1,
                                          16'sd12868, -16'sd12868};
        foreach (corner[i]) begin
            w.first_angle = corner[i];
            w.second_angle = corner[(i+1)%6];
            w.third_angle = corner[(i+2)%6];
            w.first_axis = AXIS_X; w.second_axis = AXIS_Y; w.third_axis = AXIS_Z;
            send_word(w);
        end
        w = '1;
        send_word(w);
    endtask

    // wait until nothing is in flight
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_matrices.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_random_words(int count);
        for (int n = 0; n < count; n++) begin
            send_word(random_word());
            if (n == count / 2) drain();
        end
    endtask

    initial begin
        mismatch_count = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_identity_and_axes();
        test_angle_extremes();
        test_random_words(1200);
        drain();
        repeat (LATENCY + 5) @(posedge i_clk);
        if (mismatch_count == 0 && pending_matrices.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
